// ===== hdl/lps_pkg.sv =====
`timescale 1ns / 1ps

package lps_pkg;

  // fixed field widths
  localparam int unsigned SEL_W      = 3;
  localparam int unsigned CNT_W      = 16;
  localparam int unsigned MASKS_W    = 25;
  localparam int unsigned TIMES_W    = 60;
  localparam int unsigned CFG_DATA_W = 60;
  localparam int unsigned LEVELS_W   = 5;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // register reset values
  localparam logic [SEL_W-1:0]   RST_LAMP_COUNT  = 3'd5;
  localparam logic [SEL_W-1:0]   RST_FLASH_LAMP  = 3'd2;
  localparam logic [CNT_W-1:0]   RST_FLASH_HALF  = 16'd50;
  localparam logic [SEL_W-1:0]   RST_PHASE_COUNT = 3'd0;
  localparam logic [CNT_W-1:0]   RST_LONG_PRESS  = 16'd200;
  localparam logic [CNT_W-1:0]   RST_SHUTOFF     = 16'd1500;

  // phase time loaded at reset, before the first phase change
  localparam int unsigned RST_PHASE_TIME = 100;

  typedef enum logic [1:0] {
    MODE_FLASH = 2'd0,
    MODE_CYCLE = 2'd1,
    MODE_PAUSE = 2'd2,
    MODE_SLEEP = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    REG_LAMP_COUNT  = 3'd0,
    REG_FLASH_LAMP  = 3'd1,
    REG_FLASH_HALF  = 3'd2,
    REG_PHASE_COUNT = 3'd3,
    REG_LONG_PRESS  = 3'd4,
    REG_SHUTOFF     = 3'd5,
    REG_PHASE_MASKS = 3'd6,
    REG_PHASE_TIMES = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [SEL_W-1:0]   lamp_count;
    logic [SEL_W-1:0]   flash_lamp;
    logic [CNT_W-1:0]   flash_half_period;
    logic [SEL_W-1:0]   phase_count;
    logic [CNT_W-1:0]   long_press_time;
    logic [CNT_W-1:0]   shutoff_time;
    logic [MASKS_W-1:0] phase_lamp_masks;
    logic [TIMES_W-1:0] phase_durations;
  } cfg_t;

  typedef struct packed {
    logic [LEVELS_W-1:0] lamp_levels;
    mode_e               mode_status;
    logic [SEL_W-1:0]    upcoming_phase;
  } res_t;

  // saturating tick counter increment
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

endpackage

// ===== hdl/lps_cfg_regs.sv =====
`timescale 1ns / 1ps

module lps_cfg_regs
  import lps_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [SEL_W-1:0]      cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output cfg_t                  cfg_o
);

  cfg_t     cfg_q;
  reg_idx_e idx;

  assign idx   = reg_idx_e'(cfg_idx_i);
  assign cfg_o = cfg_q;

  // register file, each write truncated to the register width
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lamp_count        <= RST_LAMP_COUNT;
      cfg_q.flash_lamp        <= RST_FLASH_LAMP;
      cfg_q.flash_half_period <= RST_FLASH_HALF;
      cfg_q.phase_count       <= RST_PHASE_COUNT;
      cfg_q.long_press_time   <= RST_LONG_PRESS;
      cfg_q.shutoff_time      <= RST_SHUTOFF;
      cfg_q.phase_lamp_masks  <= '0;
      cfg_q.phase_durations   <= '0;
    end else if (cfg_we_i) begin
      unique case (idx)
        REG_LAMP_COUNT:  cfg_q.lamp_count        <= cfg_wdata_i[SEL_W-1:0];
        REG_FLASH_LAMP:  cfg_q.flash_lamp        <= cfg_wdata_i[SEL_W-1:0];
        REG_FLASH_HALF:  cfg_q.flash_half_period <= cfg_wdata_i[CNT_W-1:0];
        REG_PHASE_COUNT: cfg_q.phase_count       <= cfg_wdata_i[SEL_W-1:0];
        REG_LONG_PRESS:  cfg_q.long_press_time   <= cfg_wdata_i[CNT_W-1:0];
        REG_SHUTOFF:     cfg_q.shutoff_time      <= cfg_wdata_i[CNT_W-1:0];
        REG_PHASE_MASKS: cfg_q.phase_lamp_masks  <= cfg_wdata_i[MASKS_W-1:0];
        REG_PHASE_TIMES: cfg_q.phase_durations   <= cfg_wdata_i[TIMES_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/lps_step.sv =====
`timescale 1ns / 1ps

module lps_step
  import lps_pkg::*;
#(
  parameter int unsigned LAMPS           = 5,
  parameter int unsigned PHASES          = 5,
  parameter int unsigned PHASE_TIME_BITS = 12
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic step_i,
  input  logic button_i,
  input  cfg_t cfg_i,
  output res_t res_o
);

  // sequencer state
  logic [LAMPS-1:0]           lamp_q, lamp_d;
  logic                       flash_mode_q, flash_mode_d;
  logic                       cyc_en_q, cyc_en_d;
  logic                       asleep_q, asleep_d;
  logic                       wake_seen_q, wake_seen_d;
  logic                       held_q, held_d;
  logic [SEL_W-1:0]           next_phase_q, next_phase_d;
  logic [PHASE_TIME_BITS-1:0] cur_time_q, cur_time_d;
  logic [CNT_W-1:0]           phase_el_q, phase_el_d;
  logic [CNT_W-1:0]           flash_el_q, flash_el_d;
  logic [CNT_W-1:0]           idle_el_q, idle_el_d;
  logic [CNT_W-1:0]           press_el_q, press_el_d;

  logic [3:0]                 lamp_num;
  logic [LAMPS-1:0]           conn;
  logic [SEL_W-1:0]           vphase;
  logic [SEL_W-1:0]           ph_idx;
  logic [7:0]                 mask_off;
  logic [7:0]                 time_off;
  logic [63:0]                mask_sh;
  logic [63:0]                time_sh;
  logic [LAMPS-1:0]           ph_mask;
  logic [PHASE_TIME_BITS-1:0] ph_time;
  logic [7:0]                 fb_full;
  logic [LAMPS-1:0]           fb;
  logic [3:0]                 np_inc;
  logic [CNT_W-1:0]           flash_inc;
  logic [CNT_W-1:0]           idle_inc;
  logic [CNT_W-1:0]           phase_inc;
  logic [LAMPS-1:0]           lamp_f;
  logic [7:0]                 lamp_ext;

  // connected lamps: zero counts as one, clipped to the lamps built
  always_comb begin
    if (cfg_i.lamp_count == '0) begin
      lamp_num = 4'd1;
    end else if ({1'b0, cfg_i.lamp_count} > 4'(LAMPS)) begin
      lamp_num = 4'(LAMPS);
    end else begin
      lamp_num = {1'b0, cfg_i.lamp_count};
    end
    for (int i = 0; i < LAMPS; i++) begin
      conn[i] = 4'(i) < lamp_num;
    end
  end

  // phase lookup, out-of-range phases fall back to phase one
  always_comb begin
    if (next_phase_q != '0 && {1'b0, next_phase_q} <= 4'(PHASES)
        && next_phase_q <= cfg_i.phase_count) begin
      vphase = next_phase_q;
    end else begin
      vphase = SEL_W'(1);
    end
    ph_idx   = vphase - SEL_W'(1);
    mask_off = 8'(ph_idx) * 8'(LAMPS);
    time_off = 8'(ph_idx) * 8'(PHASE_TIME_BITS);
    mask_sh  = (mask_off >= 8'd64) ? '0 : (64'(cfg_i.phase_lamp_masks) >> mask_off[5:0]);
    time_sh  = (time_off >= 8'd64) ? '0 : (64'(cfg_i.phase_durations) >> time_off[5:0]);
    ph_mask  = mask_sh[LAMPS-1:0];
    ph_time  = time_sh[PHASE_TIME_BITS-1:0];
  end

  // flash lamp bit, empty when unset or not connected
  assign fb_full = (cfg_i.flash_lamp != '0)
                 ? (8'd1 << (cfg_i.flash_lamp - SEL_W'(1))) : 8'd0;
  assign fb      = fb_full[LAMPS-1:0] & conn;

  assign np_inc    = {1'b0, next_phase_q} + 4'd1;
  assign flash_inc = sat_inc(flash_el_q);
  assign idle_inc  = sat_inc(idle_el_q);
  assign phase_inc = sat_inc(phase_el_q);

  // next state for one tick
  always_comb begin
    lamp_d       = lamp_q;
    flash_mode_d = flash_mode_q;
    cyc_en_d     = cyc_en_q;
    asleep_d     = asleep_q;
    wake_seen_d  = wake_seen_q;
    held_d       = held_q;
    next_phase_d = next_phase_q;
    cur_time_d   = cur_time_q;
    phase_el_d   = phase_el_q;
    flash_el_d   = flash_el_q;
    idle_el_d    = idle_el_q;
    press_el_d   = press_el_q;
    lamp_f       = lamp_q;

    priority if (asleep_q) begin
      // sleeping: wait for a full press and release
      flash_el_d = flash_inc;
      if (button_i) begin
        wake_seen_d = 1'b1;
      end else if (wake_seen_q) begin
        wake_seen_d = 1'b0;
        asleep_d    = 1'b0;
        idle_el_d   = '0;
      end
    end else if (button_i) begin
      // press timing, everything else frozen
      press_el_d = held_q ? sat_inc(press_el_q) : CNT_W'(1);
      held_d     = 1'b1;
    end else if (held_q) begin
      // release: long press selects flash, short press cycles or pauses
      held_d = 1'b0;
      if (press_el_q > cfg_i.long_press_time) begin
        flash_mode_d = 1'b1;
        next_phase_d = SEL_W'(1);
        cyc_en_d     = 1'b0;
      end else begin
        flash_mode_d = 1'b0;
        cyc_en_d     = !cyc_en_q;
      end
      press_el_d = '0;
      phase_el_d = '0;
      flash_el_d = '0;
      idle_el_d  = '0;
    end else if (flash_mode_q) begin
      // flash toggle, then idle shutoff
      flash_el_d = flash_inc;
      if (flash_inc > cfg_i.flash_half_period) begin
        lamp_f     = (lamp_q & ~conn) | ((lamp_q ^ fb) & fb);
        flash_el_d = '0;
      end
      lamp_d    = lamp_f;
      idle_el_d = idle_inc;
      if (idle_inc > cfg_i.shutoff_time) begin
        lamp_d      = lamp_f & ~conn;
        asleep_d    = 1'b1;
        wake_seen_d = 1'b0;
      end
    end else begin
      // phase cycling
      idle_el_d  = '0;
      phase_el_d = phase_inc;
      if (phase_inc > CNT_W'(cur_time_q) && cyc_en_q) begin
        lamp_d     = (lamp_q & ~conn) | (ph_mask & conn);
        cur_time_d = ph_time;
        if (np_inc > {1'b0, cfg_i.phase_count}) begin
          next_phase_d = SEL_W'(1);
        end else begin
          next_phase_d = np_inc[SEL_W-1:0];
        end
        phase_el_d = '0;
      end
    end
  end

  // state registers, advanced once per tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lamp_q       <= '0;
      flash_mode_q <= 1'b1;
      cyc_en_q     <= 1'b0;
      asleep_q     <= 1'b0;
      wake_seen_q  <= 1'b0;
      held_q       <= 1'b0;
      next_phase_q <= SEL_W'(1);
      cur_time_q   <= PHASE_TIME_BITS'(RST_PHASE_TIME);
      phase_el_q   <= '0;
      flash_el_q   <= '0;
      idle_el_q    <= '0;
      press_el_q   <= '0;
    end else if (step_i) begin
      lamp_q       <= lamp_d;
      flash_mode_q <= flash_mode_d;
      cyc_en_q     <= cyc_en_d;
      asleep_q     <= asleep_d;
      wake_seen_q  <= wake_seen_d;
      held_q       <= held_d;
      next_phase_q <= next_phase_d;
      cur_time_q   <= cur_time_d;
      phase_el_q   <= phase_el_d;
      flash_el_q   <= flash_el_d;
      idle_el_q    <= idle_el_d;
      press_el_q   <= press_el_d;
    end
  end

  // result from the updated state
  assign lamp_ext = 8'(lamp_d);

  always_comb begin
    res_o.lamp_levels    = lamp_ext[LEVELS_W-1:0];
    res_o.upcoming_phase = next_phase_d;
    priority if (asleep_d) begin
      res_o.mode_status = MODE_SLEEP;
    end else if (flash_mode_d) begin
      res_o.mode_status = MODE_FLASH;
    end else if (cyc_en_d) begin
      res_o.mode_status = MODE_CYCLE;
    end else begin
      res_o.mode_status = MODE_PAUSE;
    end
  end

endmodule

// ===== hdl/lamp_phase_sequencer.sv =====
`timescale 1ns / 1ps

// channel   direction  handshake                  payload
// tick in   input      in_valid_i / in_ready_o    button_level_i
// result    output     out_valid_o / out_ready_i  lamp_levels_o, mode_status_o,
//                                                 upcoming_phase_o
// config    input      cfg_we_i (no wait)         cfg_idx_i, cfg_wdata_i
//
// one tick beat per cycle sustained while out_ready_i holds; a taken beat passes
// the input register, then the state update into the result register
// reset puts every config register and the sequencer state at its reset value
// a stalled result holds in the result register while one more beat waits in
// the input register; in_ready_o drops only when both are full and out_ready_i is low

module lamp_phase_sequencer
  import lps_pkg::*;
#(
  parameter int unsigned LAMPS           = 5,
  parameter int unsigned PHASES          = 5,
  parameter int unsigned PHASE_TIME_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [SEL_W-1:0]      cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  button_level_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [LEVELS_W-1:0]   lamp_levels_o,
  output logic [1:0]            mode_status_o,
  output logic [SEL_W-1:0]      upcoming_phase_o
);

  cfg_t cfg;
  res_t step_res;
  res_t res_q;
  logic in_vld_q, in_vld_d;
  logic btn_q;
  logic out_vld_q, out_vld_d;
  logic adv;
  logic fire;
  logic in_take;

  lps_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  lps_step #(
    .LAMPS           (LAMPS),
    .PHASES          (PHASES),
    .PHASE_TIME_BITS (PHASE_TIME_BITS)
  ) u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (fire),
    .button_i (btn_q),
    .cfg_i    (cfg),
    .res_o    (step_res)
  );

  // pipeline control
  assign adv        = !out_vld_q || out_ready_i;
  assign fire       = in_vld_q && adv;
  assign in_ready_o = !in_vld_q || adv;
  assign in_take    = in_valid_i && in_ready_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take) begin
      in_vld_d = 1'b1;
    end else if (fire) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (fire) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // input and result payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      btn_q <= button_level_i;
    end
    if (fire) begin
      res_q <= step_res;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign lamp_levels_o    = res_q.lamp_levels;
  assign mode_status_o    = res_q.mode_status;
  assign upcoming_phase_o = res_q.upcoming_phase;

  // a shown result never names phase zero
  a_phase_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> upcoming_phase_o != '0)
    else $error("upcoming phase is zero");

  // a new result only follows a tick that went through the state update
  a_out_from_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(fire))
    else $error("result valid without a state update");

  // no beat is taken while both registers are full and the output stalls
  a_no_overrun : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && out_vld_q && !out_ready_i) |-> !in_ready_o)
    else $error("input register overrun");

  // a stalled result keeps its lamp levels
  a_res_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(res_q))
    else $error("stalled result changed");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import lps_pkg::*;

  localparam int unsigned N_LAMPS      = 5;
  localparam int unsigned N_PHASES     = 5;
  localparam int unsigned PH_BITS      = 12;
  localparam int unsigned RANDOM_TICKS = 1200;

  // mirror of the sequencer: register copies, state, and the frames still owed
  class lamp_tracker;
    logic [SEL_W-1:0]   lamp_count, flash_lamp, phase_count;
    logic [CNT_W-1:0]   flash_half, long_press, shutoff;
    logic [MASKS_W-1:0] masks;
    logic [TIMES_W-1:0] durations;

    logic [LEVELS_W-1:0] lamps;
    bit                  flashing, cycling, asleep, wake_seen, held;
    int unsigned         next_ph, ph_time, ph_cnt, fl_cnt, idle_cnt, press_cnt;

    res_t        due[$];
    int unsigned errors;

    function new();
      lamp_count  = RST_LAMP_COUNT;
      flash_lamp  = RST_FLASH_LAMP;
      flash_half  = RST_FLASH_HALF;
      phase_count = RST_PHASE_COUNT;
      long_press  = RST_LONG_PRESS;
      shutoff     = RST_SHUTOFF;
      masks       = '0;
      durations   = '0;
      lamps       = '0;
      flashing    = 1'b1;
      cycling     = 1'b0;
      asleep      = 1'b0;
      wake_seen   = 1'b0;
      held        = 1'b0;
      next_ph     = 1;
      ph_time     = RST_PHASE_TIME;
      ph_cnt      = 0;
      fl_cnt      = 0;
      idle_cnt    = 0;
      press_cnt   = 0;
      errors      = 0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        REG_LAMP_COUNT:  lamp_count  = v[SEL_W-1:0];
        REG_FLASH_LAMP:  flash_lamp  = v[SEL_W-1:0];
        REG_FLASH_HALF:  flash_half  = v[CNT_W-1:0];
        REG_PHASE_COUNT: phase_count = v[SEL_W-1:0];
        REG_LONG_PRESS:  long_press  = v[CNT_W-1:0];
        REG_SHUTOFF:     shutoff     = v[CNT_W-1:0];
        REG_PHASE_MASKS: masks       = v[MASKS_W-1:0];
        default:         durations   = v[TIMES_W-1:0];
      endcase
    endfunction

    function int unsigned bump(int unsigned v);
      return (v >= 65535) ? 65535 : v + 1;
    endfunction

    // lamps actually wired, count clamped to 1..N_LAMPS
    function logic [LEVELS_W-1:0] conn_mask();
      int unsigned n = lamp_count;
      logic [31:0] w;
      if (n == 0) n = 1;
      if (n > N_LAMPS) n = N_LAMPS;
      w = (32'd1 << n) - 1;
      return w[LEVELS_W-1:0];
    endfunction

    // phases past the configured count or the phase table fall back to phase one
    function int unsigned live_phase(int unsigned p);
      return (p >= 1 && p <= N_PHASES && p <= phase_count) ? p : 1;
    endfunction

    // advance one tick and queue the frame it produces
    function void note_tick(bit pressed);
      logic [LEVELS_W-1:0] conn, fb, toggled, pm;
      logic [31:0]         wide;
      int unsigned         p;
      res_t                r;
      conn = conn_mask();
      if (asleep) begin
        // sleeping: only a full press and release wakes
        fl_cnt = bump(fl_cnt);
        if (pressed) begin
          wake_seen = 1'b1;
        end else if (wake_seen) begin
          wake_seen = 1'b0;
          asleep    = 1'b0;
          idle_cnt  = 0;
        end
      end else if (pressed) begin
        press_cnt = held ? bump(press_cnt) : 1;
        held      = 1'b1;
      end else if (held) begin
        // release: long press goes to flash, short one toggles cycling
        held = 1'b0;
        if (press_cnt > long_press) begin
          flashing = 1'b1;
          next_ph  = 1;
          cycling  = 1'b0;
        end else begin
          flashing = 1'b0;
          cycling  = !cycling;
        end
        press_cnt = 0;
        ph_cnt    = 0;
        fl_cnt    = 0;
        idle_cnt  = 0;
      end else if (flashing) begin
        fl_cnt = bump(fl_cnt);
        if (fl_cnt > flash_half) begin
          wide    = 32'd1 << (flash_lamp - 1);
          fb      = (flash_lamp != 0) ? (wide[LEVELS_W-1:0] & conn) : '0;
          toggled = (lamps ^ fb) & fb;
          lamps   = (lamps & ~conn) | toggled;
          fl_cnt  = 0;
        end
        idle_cnt = bump(idle_cnt);
        if (idle_cnt > shutoff) begin
          lamps     = lamps & ~conn;
          asleep    = 1'b1;
          wake_seen = 1'b0;
        end
      end else begin
        // cycle mode, paused or running
        idle_cnt = 0;
        ph_cnt   = bump(ph_cnt);
        if (ph_cnt > ph_time && cycling) begin
          p       = live_phase(next_ph);
          pm      = LEVELS_W'(masks >> ((p - 1) * N_LAMPS));
          lamps   = (lamps & ~conn) | (pm & conn);
          ph_time = 32'((durations >> ((p - 1) * PH_BITS)) & 60'hFFF);
          next_ph = next_ph + 1;
          if (next_ph > phase_count) next_ph = 1;
          ph_cnt = 0;
        end
      end
      r.lamp_levels    = lamps;
      r.mode_status    = asleep ? MODE_SLEEP : flashing ? MODE_FLASH :
                         cycling ? MODE_CYCLE : MODE_PAUSE;
      r.upcoming_phase = next_ph[SEL_W-1:0];
      due.push_back(r);
    endfunction

    function void check_frame(logic [LEVELS_W-1:0] lv, logic [1:0] md,
                              logic [SEL_W-1:0] ph);
      res_t e;
      if (due.size() == 0) begin
        $error("unexpected result beat: lamp_levels %0h mode_status %0d upcoming_phase %0d",
               lv, md, ph);
        errors++;
        return;
      end
      e = due.pop_front();
      if (lv !== e.lamp_levels) begin
        $error("lamp_levels: expected %0h, got %0h", e.lamp_levels, lv);
        errors++;
      end
      if (md !== e.mode_status) begin
        $error("mode_status: expected %0d, got %0d", e.mode_status, md);
        errors++;
      end
      if (ph !== e.upcoming_phase) begin
        $error("upcoming_phase: expected %0d, got %0d", e.upcoming_phase, ph);
        errors++;
      end
    endfunction
  endclass

  typedef enum logic [1:0] {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_PULSED} rx_pattern_e;

  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  cfg_we_i       = 1'b0;
  reg_idx_e              cfg_idx_i      = REG_LAMP_COUNT;
  logic [CFG_DATA_W-1:0] cfg_wdata_i    = '0;
  logic                  in_valid_i     = 1'b0;
  logic                  button_level_i = 1'b0;
  logic                  out_ready_i    = 1'b0;
  logic                  in_ready_o;
  logic                  out_valid_o;
  logic [LEVELS_W-1:0]   lamp_levels_o;
  logic [1:0]            mode_status_o;
  logic [SEL_W-1:0]      upcoming_phase_o;

  lamp_tracker           tracker = new();
  logic [CFG_DATA_W-1:0] cfg_next [8];
  int unsigned           ticks_sent = 0;
  int unsigned           burst_left = 0;
  rx_pattern_e           rx_pattern = RX_OPEN;
  int unsigned           rx_left    = 0;

  lamp_phase_sequencer #(
    .LAMPS          (N_LAMPS),
    .PHASES         (N_PHASES),
    .PHASE_TIME_BITS(PH_BITS)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .button_level_i  (button_level_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .lamp_levels_o   (lamp_levels_o),
    .mode_status_o   (mode_status_o),
    .upcoming_phase_o(upcoming_phase_o)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // result side: check each taken beat, then pick the next ready level
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      tracker.check_frame(lamp_levels_o, mode_status_o, upcoming_phase_o);
    end
    if (rx_left == 0) begin
      rx_pattern = rx_pattern_e'($urandom_range(0, 3));
      rx_left    = $urandom_range(20, 200);
    end else begin
      rx_left--;
    end
    case (rx_pattern)
      RX_OPEN:   out_ready_i <= 1'b1;
      RX_MOSTLY: out_ready_i <= ($urandom_range(0, 3) != 0);
      RX_SPARSE: out_ready_i <= ($urandom_range(0, 3) == 0);
      default:   out_ready_i <= ((rx_left % 16) >= 10);
    endcase
  end

  // one tick beat, sent in bursts with random gaps in between
  task automatic send_tick(bit lvl);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid_i     <= 1'b1;
    button_level_i <= lvl;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.note_tick(lvl);
    burst_left--;
    ticks_sent++;
  endtask

  task automatic hold(bit lvl, int unsigned n);
    repeat (n) send_tick(lvl);
  endtask

  task automatic press(int unsigned n);
    hold(1'b1, n);
    send_tick(1'b0);
  endtask

  // stop sending and let every owed frame come out
  task automatic settle();
    in_valid_i <= 1'b0;
    while (tracker.due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_regs();
    for (int i = 0; i < 8; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= reg_idx_e'(i);
      cfg_wdata_i <= cfg_next[i];
      @(posedge clk_i);
      tracker.set_reg(reg_idx_e'(i), cfg_next[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  // random bits above the register width must be dropped by the block
  function automatic logic [CFG_DATA_W-1:0] with_junk(logic [CFG_DATA_W-1:0] field,
                                                      int unsigned w);
    logic [CFG_DATA_W-1:0] junk = CFG_DATA_W'({$urandom, $urandom});
    logic [CFG_DATA_W-1:0] keep = (60'd1 << w) - 1;
    return (junk & ~keep) | (field & keep);
  endfunction

  initial begin
    logic [TIMES_W-1:0] times;
    int unsigned        pick, lp, chunk_end, random_end;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // a few ticks at reset settings
    hold(1'b0, 3);
    settle();

    // directed: three phases with short times, fast flash, quick shutoff
    cfg_next[REG_LAMP_COUNT]  = with_junk(3'd5, SEL_W);
    cfg_next[REG_FLASH_LAMP]  = with_junk(3'd2, SEL_W);
    cfg_next[REG_FLASH_HALF]  = with_junk(16'd1, CNT_W);
    cfg_next[REG_PHASE_COUNT] = with_junk(3'd3, SEL_W);
    cfg_next[REG_LONG_PRESS]  = with_junk(16'd3, CNT_W);
    cfg_next[REG_SHUTOFF]     = with_junk(16'd6, CNT_W);
    cfg_next[REG_PHASE_MASKS] = with_junk({10'd0, 5'b11000, 5'b00110, 5'b00001}, MASKS_W);
    cfg_next[REG_PHASE_TIMES] = with_junk({24'd0, 12'd2, 12'd0, 12'd1}, TIMES_W);
    write_regs();
    hold(1'b0, 3);     // flash toggles
    press(2);          // short press enters cycling
    hold(1'b0, 103);   // runs out the reset phase time, then steps into phases one and two
    press(1);          // pause
    hold(1'b0, 3);
    press(1);          // resume
    press(4);          // long press back to flash, phase reset to one
    hold(1'b0, 8);     // idle past shutoff, lamps off and asleep
    hold(1'b1, 2);
    hold(1'b0, 3);     // release wakes, the overdue toggle follows

    // random settings, each run over a stretch of mixed press sequences
    random_end = ticks_sent + RANDOM_TICKS;
    while (ticks_sent < random_end) begin
      settle();
      cfg_next[REG_LAMP_COUNT]  = with_junk($urandom_range(0, 7), SEL_W);
      cfg_next[REG_FLASH_LAMP]  = with_junk($urandom_range(0, 7), SEL_W);
      cfg_next[REG_FLASH_HALF]  = with_junk($urandom_range(0, 8), CNT_W);
      cfg_next[REG_PHASE_COUNT] = with_junk($urandom_range(0, 7), SEL_W);
      cfg_next[REG_LONG_PRESS]  = with_junk($urandom_range(0, 10), CNT_W);
      cfg_next[REG_SHUTOFF]     = with_junk(($urandom_range(0, 4) == 0) ? 16'hFFFF :
                                            $urandom_range(0, 60), CNT_W);
      cfg_next[REG_PHASE_MASKS] = with_junk($urandom, MASKS_W);
      times = '0;
      for (int k = 0; k < N_PHASES; k++) begin
        times[k*PH_BITS +: PH_BITS] = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 60) :
                                                                   $urandom_range(0, 12);
      end
      cfg_next[REG_PHASE_TIMES] = with_junk(times, TIMES_W);
      write_regs();
      lp        = tracker.long_press;
      chunk_end = ticks_sent + $urandom_range(80, 200);
      while (ticks_sent < chunk_end) begin
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
          press((lp == 0) ? 1 : $urandom_range(1, (lp > 40) ? 40 : lp));
        end else if (pick < 50) begin
          press(lp + 1 + $urandom_range(0, 2));
        end else if (pick < 85) begin
          hold(1'b0, $urandom_range(1, 30));
        end else begin
          repeat ($urandom_range(1, 6)) send_tick($urandom_range(0, 1));
        end
      end
    end

    // all registers at their top values: the longest phase time gets loaded
    settle();
    for (int i = 0; i < 8; i++) cfg_next[i] = '1;
    write_regs();
    while (tracker.asleep || tracker.flashing || !tracker.cycling) press(1);
    hold(1'b0, 300);

    // all registers zero: one lamp, no flash lamp, every press long
    settle();
    for (int i = 0; i < 8; i++) cfg_next[i] = '0;
    write_regs();
    press(1);
    hold(1'b0, 3);
    repeat (20) send_tick($urandom_range(0, 1));

    // a press as long as the long-press time stays short, one tick more is long
    settle();
    cfg_next[REG_LONG_PRESS] = with_junk(16'd40, CNT_W);
    cfg_next[REG_SHUTOFF]    = with_junk(16'hFFFF, CNT_W);
    cfg_next[REG_FLASH_HALF] = with_junk(16'd3, CNT_W);
    write_regs();
    while (tracker.asleep || tracker.flashing) press(1);
    press(40);
    press(41);
    hold(1'b0, 5);

    settle();
    if (tracker.errors == 0 && tracker.due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/lps_pkg.sv
hdl/lps_cfg_regs.sv
hdl/lps_step.sv
hdl/lamp_phase_sequencer.sv
bench/tb_top.sv
